FILE: sv/centered_moving_average_unit_defines.svh
// assertion macros used by the checker file
// depends on: nothing; expects clock and reset in the scope of each use
`ifndef CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// property checked outside reset
`define CMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also covers the reset cycles
`define CMA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/cma_pkg.sv
// types and constants of the centered moving average unit
// depends on: nothing
package cma_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WSIZE_W     = 5;
   localparam int HALF_W      = WSIZE_W - 1;
   // a window never spans more than 31 samples, so reach and count fit here
   localparam int COUNT_W     = 5;
   localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
   localparam int DEN_W       = COUNT_W + 1;
   localparam int JOBQ_DEPTH  = 4;
   localparam int RSPQ_DEPTH  = 4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          end_of_signal;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic                          end_of_run;
   } rsp_type;

   // one averaging job: sum the newest reach+1 samples
   typedef struct packed {
      logic [COUNT_W-1:0] reach;
      logic               last;
   } job_type;

   typedef enum logic {
      F_IDLE,
      F_FLUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SUM,
      B_LAST,
      B_PREP,
      B_DIV,
      B_PUSH
   } back_state_type;

endpackage

FILE: sv/cma_fifo.sv
// small synchronous queue of packed words
// depends on: nothing
module cma_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

endmodule

FILE: sv/cma_front.sv
// front end: window register, request intake, ring writes and job generation
// depends on: cma_pkg
module cma_front #(
   parameter int MAX_WINDOW = 31,
   parameter int IDX_W      = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [cma_pkg::WSIZE_W-1:0]      csr_data,
   input  logic                             req_push,
   input  cma_pkg::req_type                 req_data,
   output logic                             req_full,
   input  logic                             back_busy,
   output logic                             ring_wr_en,
   output logic [IDX_W-1:0]                 ring_wr_addr,
   output logic [cma_pkg::SAMPLE_BITS-1:0]  ring_wr_data,
   output logic [IDX_W-1:0]                 newest_pos,
   output logic                             job_push,
   output cma_pkg::job_type                 job_data,
   input  logic                             job_full
);

   localparam int AV_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (AV_W > cma_pkg::COUNT_W) ? AV_W : cma_pkg::COUNT_W;
   localparam int HMAX  = (MAX_WINDOW - 1) / 2;

   cma_pkg::front_state_type          state_ff, state_in;
   logic [cma_pkg::WSIZE_W-1:0]       window_ff, window_in;
   logic [IDX_W-1:0]                  wp_ff, wp_in;
   logic [IDX_W-1:0]                  newest_ff, newest_in;
   logic [AV_W-1:0]                   avail_ff, avail_in;
   logic [AV_W-1:0]                   fl_avail_ff, fl_avail_in;
   logic [cma_pkg::HALF_W-1:0]        d_ff, d_in;

   logic [cma_pkg::HALF_W-1:0]        half_raw, half;
   logic                              accept;
   logic [AV_W-1:0]                   avail_new;
   logic [CMP_W-1:0]                  avail_m1, fl_m1, two_h, d_plus_h, half_x;
   logic [CMP_W-1:0]                  run_reach, fl_reach, d_first;

   // half width, limited so the whole window fits the ring
   always_comb begin
      half_raw = window_ff[cma_pkg::WSIZE_W-1:1];
      half     = (int'(half_raw) > HMAX) ? cma_pkg::HALF_W'(HMAX) : half_raw;
   end

   // window arithmetic
   always_comb begin
      avail_new = (avail_ff < AV_W'(MAX_WINDOW)) ? avail_ff + 1'b1 : avail_ff;
      avail_m1  = CMP_W'(avail_new) - 1'b1;
      fl_m1     = CMP_W'(fl_avail_ff) - 1'b1;
      half_x    = CMP_W'(half);
      two_h     = CMP_W'({half, 1'b0});
      d_plus_h  = CMP_W'(d_ff) + half_x;
      run_reach = (two_h > avail_m1) ? avail_m1 : two_h;
      fl_reach  = (d_plus_h > fl_m1) ? fl_m1 : d_plus_h;
      d_first   = (half_x < avail_m1) ? half_x : avail_m1;
   end

   // intake and flush sequencer
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      wp_in        = wp_ff;
      newest_in    = newest_ff;
      avail_in     = avail_ff;
      fl_avail_in  = fl_avail_ff;
      d_in         = d_ff;
      req_full     = 1'b1;
      accept       = 1'b0;
      ring_wr_en   = 1'b0;
      job_push     = 1'b0;
      job_data     = '{reach: '0, last: 1'b0};
      if (csr_valid) begin
         window_in = csr_data;
      end
      unique case (state_ff)
         cma_pkg::F_IDLE: begin
            req_full = back_busy;
            accept   = req_push && !back_busy;
            if (accept) begin
               ring_wr_en = 1'b1;
               newest_in  = wp_ff;
               wp_in      = (wp_ff == IDX_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
               avail_in   = avail_new;
               if (!req_data.end_of_signal) begin
                  if (CMP_W'(avail_new) > half_x) begin
                     job_push = 1'b1;
                     job_data = '{reach: cma_pkg::COUNT_W'(run_reach), last: 1'b0};
                  end
               end else begin
                  state_in    = cma_pkg::F_FLUSH;
                  d_in        = cma_pkg::HALF_W'(d_first);
                  fl_avail_in = avail_new;
                  wp_in       = '0;
                  avail_in    = '0;
               end
            end
         end
         cma_pkg::F_FLUSH: begin
            job_data = '{reach: cma_pkg::COUNT_W'(fl_reach), last: (d_ff == '0)};
            if (!job_full) begin
               job_push = 1'b1;
               if (d_ff == '0) begin
                  state_in = cma_pkg::F_IDLE;
               end else begin
                  d_in = d_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = cma_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cma_pkg::F_IDLE;
         window_ff <= cma_pkg::WSIZE_W'(1);
         wp_ff     <= '0;
         avail_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         wp_ff     <= wp_in;
         avail_ff  <= avail_in;
      end
   end

   // flush bookkeeping and newest ring slot
   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      fl_avail_ff <= fl_avail_in;
      d_ff        <= d_in;
   end

   assign ring_wr_addr = wp_ff;
   assign ring_wr_data = req_data.sample;
   assign newest_pos   = newest_ff;

endmodule

FILE: sv/cma_back.sv
// back end: sample ring, window sum sequencer and rounding radix-2 divider
// depends on: cma_pkg
module cma_back #(
   parameter int MAX_WINDOW = 31,
   parameter int IDX_W      = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             ring_wr_en,
   input  logic [IDX_W-1:0]                 ring_wr_addr,
   input  logic [cma_pkg::SAMPLE_BITS-1:0]  ring_wr_data,
   input  logic [IDX_W-1:0]                 newest_pos,
   input  logic                             job_empty,
   input  cma_pkg::job_type                 job_data,
   output logic                             job_pop,
   input  logic                             rsp_full,
   output logic                             rsp_push,
   output cma_pkg::rsp_type                 rsp_data,
   output logic                             busy
);

   localparam int SUM_W = cma_pkg::SUM_W;
   localparam int DEN_W = cma_pkg::DEN_W;
   localparam int IT_W  = $clog2(SUM_W);

   logic [cma_pkg::SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [cma_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   cma_pkg::back_state_type         state_ff, state_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                addr_ff, addr_in;
   logic [cma_pkg::COUNT_W-1:0]     issued_ff, issued_in;
   logic [cma_pkg::COUNT_W-1:0]     reach_ff, reach_in;
   logic                            last_ff, last_in;
   logic signed [SUM_W-1:0]         sum_ff, sum_in;
   logic                            neg_ff, neg_in;
   logic [SUM_W-1:0]                nq_ff, nq_in;
   logic [DEN_W-1:0]                rem_ff, rem_in;
   logic [DEN_W-1:0]                den_ff, den_in;
   logic [IT_W-1:0]                 iter_ff, iter_in;

   logic signed [SUM_W-1:0]         rd_ext, sum_acc;
   logic [IDX_W-1:0]                addr_prev;
   logic [cma_pkg::COUNT_W-1:0]     count;
   logic [SUM_W-1:0]                mag, num;
   logic [DEN_W:0]                  rem_sh, diff;
   logic                            ge;
   logic [cma_pkg::SAMPLE_BITS-1:0] quot;

   // sample ring with registered read
   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[ring_wr_addr] <= ring_wr_data;
      end
      rd_data_ff <= ring_mem[addr_ff];
   end

   // datapath pieces
   always_comb begin
      rd_ext    = {{cma_pkg::COUNT_W{rd_data_ff[cma_pkg::SAMPLE_BITS-1]}}, rd_data_ff};
      sum_acc   = sum_ff + rd_ext;
      addr_prev = (addr_ff == '0) ? IDX_W'(MAX_WINDOW - 1) : addr_ff - 1'b1;
      count     = reach_ff + 1'b1;
      mag       = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      num       = {mag[SUM_W-2:0], 1'b0} + SUM_W'(count);
      rem_sh    = {rem_ff, nq_ff[SUM_W-1]};
      ge        = (rem_sh >= {1'b0, den_ff});
      diff      = rem_sh - {1'b0, den_ff};
      quot      = nq_ff[cma_pkg::SAMPLE_BITS-1:0];
   end

   // job sequencer
   always_comb begin
      state_in  = state_ff;
      rd_vld_in = (state_ff == cma_pkg::B_SUM);
      addr_in   = addr_ff;
      issued_in = issued_ff;
      reach_in  = reach_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      neg_in    = neg_ff;
      nq_in     = nq_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      iter_in   = iter_ff;
      job_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = '{average: neg_ff ? -quot : quot, end_of_run: last_ff};
      unique case (state_ff)
         cma_pkg::B_IDLE: begin
            if (!job_empty) begin
               job_pop   = 1'b1;
               reach_in  = job_data.reach;
               last_in   = job_data.last;
               addr_in   = newest_pos;
               issued_in = '0;
               sum_in    = '0;
               state_in  = cma_pkg::B_SUM;
            end
         end
         cma_pkg::B_SUM: begin
            if (rd_vld_ff) begin
               sum_in = sum_acc;
            end
            addr_in   = addr_prev;
            issued_in = issued_ff + 1'b1;
            if (issued_ff == reach_ff) begin
               state_in = cma_pkg::B_LAST;
            end
         end
         cma_pkg::B_LAST: begin
            sum_in   = sum_acc;
            state_in = cma_pkg::B_PREP;
         end
         cma_pkg::B_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            nq_in    = num;
            rem_in   = '0;
            den_in   = {count, 1'b0};
            iter_in  = '0;
            state_in = cma_pkg::B_DIV;
         end
         cma_pkg::B_DIV: begin
            rem_in  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            nq_in   = {nq_ff[SUM_W-2:0], ge};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IT_W'(SUM_W - 1)) begin
               state_in = cma_pkg::B_PUSH;
            end
         end
         cma_pkg::B_PUSH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = cma_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = cma_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cma_pkg::B_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      issued_ff <= issued_in;
      reach_ff  <= reach_in;
      last_ff   <= last_in;
      sum_ff    <= sum_in;
      neg_ff    <= neg_in;
      nq_ff     <= nq_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      iter_ff   <= iter_in;
   end

   assign busy = (state_ff != cma_pkg::B_IDLE);

endmodule

FILE: sv/centered_moving_average_unit.sv
// top level of the centered moving average unit
// depends on: cma_pkg, cma_fifo, cma_front, cma_back
//
//   channel   ports                         direction   moves
//   req       req_push req_full req_data    in          one sample request
//   rsp       rsp_pop rsp_empty rsp_data    out         one windowed mean
//   csr       csr_valid csr_ready csr_data  in          window_size write
//
// in the back end each result runs through these steps: the job is taken,
// reach + 1 ring reads are made (one ring port), the sum is finished and the
// divider set up, 21 steps of the radix-2 divider run, and the result is queued
// when the result queue has room. a request is taken only once the back end
// has drained, as results read the ring that requests write.
// reset is synchronous and clears all queues; csr writes are always taken.
module centered_moving_average_unit #(
   parameter int MAX_WINDOW = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  cma_pkg::req_type            req_data,
   output logic                        req_full,
   input  logic                        rsp_pop,
   output cma_pkg::rsp_type            rsp_data,
   output logic                        rsp_empty,
   input  logic                        csr_valid,
   input  logic [cma_pkg::WSIZE_W-1:0] csr_data,
   output logic                        csr_ready
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int JOB_W = $bits(cma_pkg::job_type);
   localparam int RSP_W = $bits(cma_pkg::rsp_type);

   logic                            ring_wr_en;
   logic [IDX_W-1:0]                ring_wr_addr;
   logic [cma_pkg::SAMPLE_BITS-1:0] ring_wr_data;
   logic [IDX_W-1:0]                newest_pos;
   logic                            job_push, job_full, job_pop, job_empty;
   cma_pkg::job_type                job_wr, job_rd;
   logic                            rsp_push, rsp_full;
   cma_pkg::rsp_type                rsp_wr;
   logic                            back_busy, back_pending;

   // front end waits while any job is queued or running
   assign back_pending = back_busy || !job_empty;
   assign csr_ready    = 1'b1;

   cma_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .back_busy    (back_pending),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .newest_pos   (newest_pos),
      .job_push     (job_push),
      .job_data     (job_wr),
      .job_full     (job_full)
   );

   // jobs between front and back
   cma_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (cma_pkg::JOBQ_DEPTH)
   ) u_jobq (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   cma_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .newest_pos   (newest_pos),
      .job_empty    (job_empty),
      .job_data     (job_rd),
      .job_pop      (job_pop),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_data     (rsp_wr),
      .busy         (back_busy)
   );

   // results waiting for the consumer
   cma_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (cma_pkg::RSPQ_DEPTH)
   ) u_rspq (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

FILE: sv/cma_checker.sv
// port-level checks of the centered moving average unit, bound to the top
// depends on: cma_pkg, centered_moving_average_unit_defines.svh
`include "centered_moving_average_unit_defines.svh"

module cma_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input cma_pkg::req_type req_data,
   input logic             req_full,
   input logic             rsp_pop,
   input cma_pkg::rsp_type rsp_data,
   input logic             rsp_empty
);

   logic last_taken;
   logic rsp_waiting;

   // handshake conditions
   assign last_taken  = req_push && !req_full && req_data.end_of_signal;
   assign rsp_waiting = !rsp_empty && !rsp_pop;

   // result queue comes out of reset empty
   `CMA_ASSERT_RST(a_rsp_empty_after_reset, reset |=> rsp_empty, "result queue not empty after reset")

   // intake is open right after reset
   `CMA_ASSERT_RST(a_req_open_after_reset, reset |=> !req_full, "request side full after reset")

   // a last sample always starts a flush, which closes intake
   `CMA_ASSERT(a_flush_closes_intake, last_taken |=> req_full, "no flush after last sample")

   // a waiting result holds until taken
   `CMA_ASSERT(a_rsp_holds, rsp_waiting |=> !rsp_empty && $stable(rsp_data), "result changed")

endmodule

bind centered_moving_average_unit cma_checker u_checker (.*);
